@@ hw/rtl/lz77_tag_stream_decompressor_assert.svh @@
// Assertion macros used by the checker file of the tag stream decompressor.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef LZ77_TAG_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZ77_TAG_STREAM_DECOMPRESSOR_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define LZTSD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle that implies a consequence in the next cycle.
`define LZTSD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lztsd_pkg.sv @@
// Shared types and constants of the tag stream decompressor.
// Used by the output buffer and the top level.
package lztsd_pkg;

  // Default history window size in bytes (legal range 2048 to 1048576).
  localparam int unsigned HistoryDepthDflt = 65536;

  // Low two bits of a tag byte.
  localparam logic [1:0] TagLiteral = 2'b00;
  localparam logic [1:0] TagCopy1   = 2'b01;
  localparam logic [1:0] TagCopy2   = 2'b10;
  localparam logic [1:0] TagCopy4   = 2'b11;

  // Inline literal lengths stop below this code; codes from it up count length bytes.
  localparam logic [5:0] LitLenInline = 6'd60;
  // Short copies carry a length of three bits plus this bias.
  localparam logic [6:0] Copy1LenBias = 7'd4;

  typedef enum logic [2:0] {
    ST_TAG,
    ST_LITLEN,
    ST_LITDATA,
    ST_COPYOFF,
    ST_CHECK,
    ST_CP_RD,
    ST_CP_WR
  } state_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       last_of_run;
    logic       copy_error;
    logic       done_res;
  } result_t;

endpackage

@@ hw/rtl/lztsd_if.sv @@
// Valid/ready channel interfaces of the tag stream decompressor.
// Fixed payload widths; no dependencies.
interface lztsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lztsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       last_of_run;
  logic       copy_error;
  logic       done_res;

  modport source (output valid, output out_byte, output out_valid, output last_of_run,
                  output copy_error, output done_res, input ready);
  modport sink (input valid, input out_byte, input out_valid, input last_of_run,
                input copy_error, input done_res, output ready);
endinterface

interface lztsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] output_length;

  modport source (output valid, output output_length, input ready);
  modport sink (input valid, input output_length, output ready);
endinterface

@@ hw/rtl/lztsd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lztsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lztsd_out_buf.sv @@
// Two-entry result queue that drives the output channel of the decompressor.
// Depends on lztsd_pkg (result_t) and lztsd_out_if.
module lztsd_out_buf
  import lztsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    space_o,
  lztsd_out_if.source out_o
);

  localparam logic [1:0] BufDepth = 2'd2;

  logic [1:0] cnt_q, cnt_d;
  result_t    head_q, tail_q;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && out_o.ready;
  assign space_o = (cnt_q != BufDepth);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The caller pushes only while there is space, so a full queue never takes a beat.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q == BufDepth) begin
        head_q <= tail_q;
      end else if (push_i) begin
        head_q <= res_i;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        head_q <= res_i;
      end else begin
        tail_q <= res_i;
      end
    end
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.out_byte    = head_q.out_byte;
  assign out_o.out_valid   = head_q.out_valid;
  assign out_o.last_of_run = head_q.last_of_run;
  assign out_o.copy_error  = head_q.copy_error;
  assign out_o.done_res    = head_q.done_res;

endmodule

@@ hw/rtl/lz77_tag_stream_decompressor.sv @@
// Raw-block decompressor for a byte-wide tag stream (the length preamble is not part of the
// stream; load the expected output size into output_length first). Each input beat gives
// results on the output channel: tag, length and non-final offset bytes give one result with
// out_valid low, a literal byte gives one data result, and the final offset byte of a copy
// gives one data result per copied byte (1 to 64) or a single result with copy_error set.
// Any byte other than a final copy offset is taken while the two-entry result queue has room.
// A copy first checks the offset (ST_CHECK) and then reads (ST_CP_RD) and writes (ST_CP_WR)
// each copied byte, since every byte is read from the history RAM (registered read) and written
// back at the head before the next read, which keeps overlapping copies exact. The input is
// held for the whole copy, and a full result queue stalls it. No clearing pass follows reset.
// Depends on lztsd_pkg, lztsd_if, lztsd_ram and lztsd_out_buf.
module lz77_tag_stream_decompressor
  import lztsd_pkg::*;
#(
  parameter int unsigned HistoryDepth = HistoryDepthDflt
) (
  input  logic clk_i,
  input  logic rst_ni,
  lztsd_cfg_if.sink   cfg_i,
  lztsd_in_if.sink    in_i,
  lztsd_out_if.source out_o
);

  localparam int unsigned AddrW  = $clog2(HistoryDepth);
  localparam logic [31:0] DepthW = 32'(HistoryDepth);
  localparam logic [AddrW:0] DepthA = (AddrW + 1)'(HistoryDepth);
  localparam logic [AddrW:0] LastA  = (AddrW + 1)'(HistoryDepth - 1);

  state_e             state_q, state_d;
  logic [AddrW-1:0]   wp_q, wp_d;
  logic [AddrW-1:0]   rd_q, rd_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [32:0]        lit_rem_q, lit_rem_d;
  logic [6:0]         copy_len_q, copy_len_d;
  logic [31:0]        acc_q, acc_d;
  logic [2:0]         left_q, left_d;
  logic [1:0]         pos_q, pos_d;
  logic [31:0]        out_len_q;

  logic               ram_we, ram_re;
  logic [7:0]         ram_wdata, ram_rdata;
  logic               push, space;
  result_t            push_res;

  logic               in_acc;
  logic [5:0]         tag_len;
  logic [AddrW-1:0]   wp_inc, rd_inc;
  logic [31:0]        cnt_inc;
  logic [31:0]        acc_new;
  logic               off_err;
  logic [AddrW:0]     off_a, wp_x, rd_diff, rd_wrap;
  logic               done_now, done_inc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= 32'd0;
    end else if (cfg_i.valid) begin
      out_len_q <= cfg_i.output_length;
    end
  end

  assign in_i.ready = space && (state_q == ST_TAG || state_q == ST_LITLEN ||
                                state_q == ST_LITDATA || state_q == ST_COPYOFF);
  assign in_acc  = in_i.valid && in_i.ready;
  assign tag_len = in_i.in_byte[7:2];

  assign wp_inc  = ({1'b0, wp_q} == LastA) ? '0 : wp_q + AddrW'(1);
  assign rd_inc  = ({1'b0, rd_q} == LastA) ? '0 : rd_q + AddrW'(1);
  assign cnt_inc = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;
  assign acc_new = acc_q | (32'(in_i.in_byte) << {pos_q, 3'b000});

  assign done_now = (cnt_q >= out_len_q);
  assign done_inc = (cnt_inc >= out_len_q);

  // Offset check and start of the copy; the start wraps back into the window, and a valid
  // offset never exceeds the window size, so one conditional add is enough.
  assign off_err = (acc_q == 32'd0) || (acc_q > cnt_q) || (acc_q > DepthW);
  assign off_a   = acc_q[AddrW:0];
  assign wp_x    = {1'b0, wp_q};
  assign rd_diff = wp_x - off_a;
  assign rd_wrap = (wp_x < off_a) ? rd_diff + DepthA : rd_diff;

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    rd_d       = rd_q;
    cnt_d      = cnt_q;
    lit_rem_d  = lit_rem_q;
    copy_len_d = copy_len_q;
    acc_d      = acc_q;
    left_d     = left_q;
    pos_d      = pos_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_wdata  = in_i.in_byte;
    push       = 1'b0;
    push_res   = '{out_byte: 8'h00, out_valid: 1'b0, last_of_run: 1'b1,
                   copy_error: 1'b0, done_res: done_now};

    case (state_q)
      ST_TAG: begin
        if (in_acc) begin
          push   = 1'b1;
          acc_d  = 32'd0;
          pos_d  = 2'd0;
          case (in_i.in_byte[1:0])
            TagLiteral: begin
              if (tag_len < LitLenInline) begin
                lit_rem_d = 33'(tag_len) + 33'd1;
                state_d   = ST_LITDATA;
              end else begin
                left_d  = 3'(tag_len - (LitLenInline - 6'd1));
                state_d = ST_LITLEN;
              end
            end
            TagCopy1: begin
              copy_len_d = 7'(in_i.in_byte[4:2]) + Copy1LenBias;
              acc_d      = {21'd0, in_i.in_byte[7:5], 8'd0};
              left_d     = 3'd1;
              state_d    = ST_COPYOFF;
            end
            TagCopy2: begin
              copy_len_d = 7'(tag_len) + 7'd1;
              left_d     = 3'd2;
              state_d    = ST_COPYOFF;
            end
            default: begin
              copy_len_d = 7'(tag_len) + 7'd1;
              left_d     = 3'd4;
              state_d    = ST_COPYOFF;
            end
          endcase
        end
      end

      ST_LITDATA: begin
        if (in_acc) begin
          ram_we    = 1'b1;
          wp_d      = wp_inc;
          cnt_d     = cnt_inc;
          lit_rem_d = lit_rem_q - 33'd1;
          if (lit_rem_q == 33'd1) begin
            state_d = ST_TAG;
          end
          push     = 1'b1;
          push_res = '{out_byte: in_i.in_byte, out_valid: 1'b1, last_of_run: 1'b1,
                       copy_error: 1'b0, done_res: done_inc};
        end
      end

      ST_LITLEN, ST_COPYOFF: begin
        if (in_acc) begin
          acc_d  = acc_new;
          pos_d  = pos_q + 2'd1;
          left_d = left_q - 3'd1;
          if (left_q != 3'd1) begin
            push = 1'b1;
          end else if (state_q == ST_LITLEN) begin
            lit_rem_d = {1'b0, acc_new} + 33'd1;
            state_d   = ST_LITDATA;
            push      = 1'b1;
          end else begin
            // The results of the final offset byte come from the copy sequence.
            state_d = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (off_err) begin
          if (space) begin
            push     = 1'b1;
            push_res = '{out_byte: 8'h00, out_valid: 1'b0, last_of_run: 1'b1,
                         copy_error: 1'b1, done_res: done_now};
            state_d  = ST_TAG;
          end
        end else begin
          rd_d    = rd_wrap[AddrW-1:0];
          state_d = ST_CP_RD;
        end
      end

      ST_CP_RD: begin
        ram_re  = 1'b1;
        rd_d    = rd_inc;
        state_d = ST_CP_WR;
      end

      ST_CP_WR: begin
        if (space) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata;
          wp_d       = wp_inc;
          cnt_d      = cnt_inc;
          copy_len_d = copy_len_q - 7'd1;
          push       = 1'b1;
          push_res   = '{out_byte: ram_rdata, out_valid: 1'b1,
                         last_of_run: (copy_len_q == 7'd1), copy_error: 1'b0,
                         done_res: done_inc};
          state_d    = (copy_len_q == 7'd1) ? ST_TAG : ST_CP_RD;
        end
      end

      default: begin
        state_d = ST_TAG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_TAG;
      wp_q       <= '0;
      rd_q       <= '0;
      cnt_q      <= 32'd0;
      lit_rem_q  <= 33'd0;
      copy_len_q <= 7'd0;
      acc_q      <= 32'd0;
      left_q     <= 3'd0;
      pos_q      <= 2'd0;
    end else begin
      state_q    <= state_d;
      wp_q       <= wp_d;
      rd_q       <= rd_d;
      cnt_q      <= cnt_d;
      lit_rem_q  <= lit_rem_d;
      copy_len_q <= copy_len_d;
      acc_q      <= acc_d;
      left_q     <= left_d;
      pos_q      <= pos_d;
    end
  end

  lztsd_ram #(
    .Width (8),
    .Depth (HistoryDepth)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  lztsd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (push_res),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule

@@ hw/rtl/lztsd_checker.sv @@
// Port-level checks of the tag stream decompressor output channel, bound to the top level.
// Depends on lz77_tag_stream_decompressor_assert.svh.
`include "lz77_tag_stream_decompressor_assert.svh"

module lztsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       o_vld_i,
  input logic       o_rdy_i,
  input logic [7:0] o_byte_i,
  input logic       o_data_i,
  input logic       o_last_i,
  input logic       o_err_i,
  input logic       o_done_i
);

  // A stalled beat keeps its whole payload.
  `LZTSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, o_vld_i && !o_rdy_i, o_vld_i && $stable({o_byte_i, o_data_i, o_last_i, o_err_i, o_done_i}), "stalled output beat changed")

  // Control and error results carry a zero byte and close the run of their input byte.
  `LZTSD_ASSERT(a_ctrl_zero, clk_i, rst_ni, (o_vld_i && !o_data_i) |-> (o_byte_i == 8'h00 && o_last_i), "non-data result with payload or open run")

  // A rejected copy never carries data.
  `LZTSD_ASSERT(a_err_no_data, clk_i, rst_ni, (o_vld_i && o_err_i) |-> !o_data_i, "copy error flagged on a data result")

  // The result queue comes out of reset empty.
  `LZTSD_ASSERT(a_reset_empty, clk_i, rst_ni, $rose(rst_ni) |-> !o_vld_i, "output valid right after reset")

endmodule

bind lz77_tag_stream_decompressor lztsd_checker u_lztsd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .o_vld_i  (out_o.valid),
  .o_rdy_i  (out_o.ready),
  .o_byte_i (out_o.out_byte),
  .o_data_i (out_o.out_valid),
  .o_last_i (out_o.last_of_run),
  .o_err_i  (out_o.copy_error),
  .o_done_i (out_o.done_res)
);
